// ===== rtl/ulrc_pkg.sv =====
// Shared types, constants, the mu-law expansion and rate clamping for the rate converter.
package ulrc_pkg;

   localparam int unsigned MAX_CHANNELS_DEF = 8;
   localparam int unsigned MAX_RATIO_DEF    = 24;
   localparam int unsigned SAMPLE_W         = 16;
   localparam int unsigned RATE_W           = 18;
   localparam int unsigned PHASE_W          = 19;
   localparam int unsigned SUM_W            = 21;
   localparam int unsigned CHAN_W           = 4;
   localparam int unsigned CSR_IDX_W        = 2;
   localparam int unsigned CSR_DATA_W       = 18;
   localparam logic [RATE_W-1:0] RATE_MIN   = 18'd8000;
   localparam logic [RATE_W-1:0] RATE_MAX   = 18'd192000;
   localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;
   localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ULAW     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_RATE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 2'd3;

   // conversion mode chosen by the front end
   typedef enum logic [1:0] {
      MODE_PASS = 2'd0,
      MODE_UP   = 2'd1,
      MODE_DOWN = 2'd2
   } mode_type;

   // back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_UP    = 3'd1,
      ST_ACCUM = 3'd2,
      ST_DIV   = 3'd3,
      ST_EMIT  = 3'd4
   } state_type;

   // mu-law code to linear PCM, range fits in 16 bits signed
   function automatic logic signed [SAMPLE_W-1:0] ulaw_expand(input logic [7:0] code);
      logic [7:0]  u;
      logic [15:0] t;
      begin
         u = ~code;
         t = (16'({u[3:0], 3'b000}) + 16'h0084) << u[6:4];
         ulaw_expand = u[7] ? SAMPLE_W'(16'h0084 - t) : SAMPLE_W'(t - 16'h0084);
      end
   endfunction

   function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
      begin
         if (r < RATE_MIN)      clamp_rate = RATE_MIN;
         else if (r > RATE_MAX) clamp_rate = RATE_MAX;
         else                   clamp_rate = r;
      end
   endfunction

endpackage

// ===== rtl/ulrc_front.sv =====
// Front end: decodes the frame, masks unused channels and picks the mode.
module ulrc_front #(
   parameter int unsigned MAX_CHANNELS = ulrc_pkg::MAX_CHANNELS_DEF
) (
   input  logic                                   in_valid,
   input  logic [MAX_CHANNELS-1:0][ulrc_pkg::SAMPLE_W-1:0] in_raw,
   input  logic                                   in_restart,
   input  logic                                   ulaw_enable,
   input  logic [ulrc_pkg::RATE_W-1:0]            in_rate,
   input  logic [ulrc_pkg::RATE_W-1:0]            out_rate,
   input  logic [ulrc_pkg::CHAN_W-1:0]            channel_count,
   input  logic                                   q_full,
   output logic                                   in_ready,
   output logic                                   q_push,
   output logic [MAX_CHANNELS-1:0][ulrc_pkg::SAMPLE_W-1:0] q_frame,
   output logic                                   q_restart,
   output ulrc_pkg::mode_type                     q_mode,
   output logic [ulrc_pkg::RATE_W-1:0]            q_ir,
   output logic [ulrc_pkg::RATE_W-1:0]            q_or,
   output logic [ulrc_pkg::CHAN_W-1:0]            q_nch
);
   import ulrc_pkg::*;

   logic [CHAN_W-1:0] nch;
   logic [RATE_W-1:0] ir, orr;

   // channel count and rate saturation
   always_comb begin
      if (channel_count == '0)                         nch = CHAN_W'(1);
      else if (32'(channel_count) > MAX_CHANNELS)      nch = CHAN_W'(MAX_CHANNELS);
      else                                             nch = channel_count;
      ir  = clamp_rate(in_rate);
      orr = clamp_rate(out_rate);
   end

   assign in_ready = !q_full;
   assign q_push   = in_valid && !q_full;

   // per-channel decode
   always_comb begin
      for (int c = 0; c < int'(MAX_CHANNELS); c++) begin
         if (c >= int'(nch))  q_frame[c] = '0;
         else if (ulaw_enable) q_frame[c] = ulaw_expand(in_raw[c][7:0]);
         else                  q_frame[c] = in_raw[c];
      end
   end

   always_comb begin
      if (ir == orr)     q_mode = MODE_PASS;
      else if (orr > ir) q_mode = MODE_UP;
      else               q_mode = MODE_DOWN;
   end

   assign q_restart = in_restart;
   assign q_ir      = ir;
   assign q_or      = orr;
   assign q_nch     = nch;
endmodule

// ===== rtl/ulrc_fifo.sv =====
// Short command queue between the front end and the back end.
module ulrc_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [AW:0]      cnt_ff;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && !full)
            wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + AW'(1);
         if (pop && !empty)
            rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
      end
   end
endmodule

// ===== rtl/ulrc_back.sv =====
// Back end: phase accumulator, span sums, serial divider and result register.
module ulrc_back #(
   parameter int unsigned MAX_CHANNELS = ulrc_pkg::MAX_CHANNELS_DEF,
   parameter int unsigned MAX_RATIO    = ulrc_pkg::MAX_RATIO_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   cmd_valid,
   output logic                                   cmd_pop,
   input  logic [MAX_CHANNELS-1:0][ulrc_pkg::SAMPLE_W-1:0] cmd_frame,
   input  logic                                   cmd_restart,
   input  ulrc_pkg::mode_type                     cmd_mode,
   input  logic [ulrc_pkg::RATE_W-1:0]            cmd_ir,
   input  logic [ulrc_pkg::RATE_W-1:0]            cmd_or,
   input  logic [ulrc_pkg::CHAN_W-1:0]            cmd_nch,
   output logic                                   rsp_valid,
   input  logic                                   rsp_take,
   output logic [MAX_CHANNELS-1:0][ulrc_pkg::SAMPLE_W-1:0] rsp_data,
   output logic                                   rsp_last
);
   import ulrc_pkg::*;

   localparam int unsigned RW  = $clog2(MAX_RATIO + 1);
   localparam int unsigned CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int unsigned DIVW = SUM_W;

   state_type state_ff, state_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [RW-1:0]      count_ff, count_in;
   logic [RW-1:0]      rep_ff, rep_in;
   logic signed [SUM_W-1:0] sums_ff [MAX_CHANNELS];
   logic [CW-1:0]      ch_ff, ch_in;
   logic [4:0]         bit_ff, bit_in;
   logic [DIVW-1:0]    quo_ff, rem_ff;
   logic               neg_ff;
   logic               rv_ff;
   logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] rd_ff;
   logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] avg_ff;
   logic               rl_ff;

   logic [PHASE_W-1:0] ph_base, ph_add, ir_ext;
   logic               out_free;
   logic               close_span;

   assign out_free  = !rv_ff || rsp_take;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;
   assign rsp_last  = rl_ff;

   assign ir_ext  = PHASE_W'(cmd_ir);
   assign ph_base = cmd_restart ? '0 : phase_ff;
   assign ph_add  = ph_base + PHASE_W'(cmd_or);

   // next state
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      rep_in     = rep_ff;
      ch_in      = ch_ff;
      bit_in     = bit_ff;
      close_span = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_mode)
                  MODE_PASS: begin
                     if (cmd_restart) begin
                        phase_in = '0;
                        count_in = '0;
                     end
                     if (out_free) state_in = ST_IDLE;
                  end
                  MODE_UP: begin
                     phase_in = ph_add;
                     rep_in   = '0;
                     if (cmd_restart) count_in = '0;
                     state_in = ST_UP;
                  end
                  MODE_DOWN: state_in = ST_ACCUM;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_UP: begin
            // one repeat per cycle while the phase crosses in_rate and the output is free
            if (phase_ff >= ir_ext && 32'(rep_ff) < MAX_RATIO) begin
               if (out_free) begin
                  phase_in = phase_ff - ir_ext;
                  rep_in   = rep_ff + RW'(1);
               end
            end else begin
               // cap reached or no crossing left: reduce modulo in_rate, a step per cycle, then go idle
               if (phase_ff >= ir_ext) phase_in = phase_ff - ir_ext;
               else if (out_free || !rv_ff) state_in = ST_IDLE;
            end
         end
         ST_ACCUM: begin
            count_in = (cmd_restart ? '0 : count_ff) + RW'(1);
            phase_in = ph_add;
            close_span = (ph_add >= ir_ext) || (32'(count_in) >= MAX_RATIO);
            if (close_span) begin
               if (ph_add >= ir_ext) phase_in = ph_add - ir_ext;
               ch_in    = '0;
               bit_in   = 5'(DIVW + 1);
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (bit_ff != '0) bit_in = bit_ff - 5'd1;
            else if (32'(ch_ff) == MAX_CHANNELS - 1) state_in = ST_EMIT;
            else begin
               ch_in  = ch_ff + CW'(1);
               bit_in = 5'(DIVW + 1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // queue pop: pass on free output, up at end, accumulate without close, emit
   always_comb begin
      cmd_pop = 1'b0;
      case (state_ff)
         ST_IDLE:  cmd_pop = cmd_valid && cmd_mode == MODE_PASS && out_free;
         ST_UP:    cmd_pop = !(phase_ff >= ir_ext) && (out_free || !rv_ff);
         ST_ACCUM: cmd_pop = !close_span;
         ST_EMIT:  cmd_pop = out_free;
         default:  cmd_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         count_ff <= '0;
         rep_ff   <= '0;
         ch_ff    <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         rep_ff   <= rep_in;
         ch_ff    <= ch_in;
         bit_ff   <= bit_in;
      end
   end

   // span sums: cleared by reset, restart and after emit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < int'(MAX_CHANNELS); c++) sums_ff[c] <= '0;
      end else if (state_ff == ST_IDLE && cmd_valid && cmd_restart) begin
         for (int c = 0; c < int'(MAX_CHANNELS); c++) sums_ff[c] <= '0;
      end else if (state_ff == ST_ACCUM) begin
         for (int c = 0; c < int'(MAX_CHANNELS); c++)
            sums_ff[c] <= sums_ff[c] + SUM_W'($signed(cmd_frame[c]));
      end else if (state_ff == ST_EMIT && out_free) begin
         for (int c = 0; c < int'(MAX_CHANNELS); c++) sums_ff[c] <= '0;
      end
   end

   // restoring divider on |sum| by count, one quotient bit per cycle
   logic [DIVW-1:0] mag;
   logic [DIVW:0]   trial;
   always_comb begin
      mag   = sums_ff[ch_ff][SUM_W-1] ? DIVW'(-sums_ff[ch_ff]) : DIVW'(sums_ff[ch_ff]);
      trial = {rem_ff, quo_ff[DIVW-1]} - (DIVW+1)'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_ACCUM || (state_ff == ST_DIV && bit_ff == '0)) begin
         rem_ff <= '0;
         quo_ff <= '0;
      end
      if (state_ff == ST_DIV) begin
         if (bit_ff == 5'(DIVW + 1)) begin
            quo_ff <= mag;
            rem_ff <= '0;
            neg_ff <= sums_ff[ch_ff][SUM_W-1];
         end else if (bit_ff != '0) begin
            if (!trial[DIVW]) begin
               rem_ff <= trial[DIVW-1:0];
               quo_ff <= {quo_ff[DIVW-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[DIVW-2:0], quo_ff[DIVW-1]};
               quo_ff <= {quo_ff[DIVW-2:0], 1'b0};
            end
         end
      end
   end

   // averages collect here so a waiting beat is left alone
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && bit_ff == '0)
         avg_ff[ch_ff] <= (32'(ch_ff) < 32'(cmd_nch))
                          ? (neg_ff ? SAMPLE_W'(-quo_ff) : SAMPLE_W'(quo_ff)) : '0;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         if (rsp_take) rv_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (cmd_valid && cmd_mode == MODE_PASS && out_free) rv_ff <= 1'b1;
            ST_UP: if (phase_ff >= ir_ext && 32'(rep_ff) < MAX_RATIO && out_free)
                      rv_ff <= 1'b1;
            ST_EMIT: if (out_free) rv_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (cmd_valid && cmd_mode == MODE_PASS && out_free) begin
            rd_ff <= cmd_frame;
            rl_ff <= 1'b1;
         end
         ST_UP: if (phase_ff >= ir_ext && 32'(rep_ff) < MAX_RATIO && out_free) begin
            rd_ff <= cmd_frame;
            rl_ff <= !((phase_ff - ir_ext) >= ir_ext && 32'(rep_ff) + 1 < MAX_RATIO);
         end
         ST_EMIT: if (out_free) begin
            rd_ff <= avg_ff;
            rl_ff <= 1'b1;
         end
         default: ;
      endcase
   end
endmodule

// ===== rtl/ulaw_decode_rate_converter.sv =====
// Top level of the mu-law decoder with box rate converter.
// Usage:
//  - req_ channel: one interleaved frame per beat, pushed while full is low.
//  - rsp_ channel: converted frames, popped while empty is low; last marks
//    the final frame caused by an input frame.
//  - csr_ port: write-only registers (mu-law enable, rates, channel count);
//    the user must write them only while the block is idle (not enforced).
// Timing: the front end decodes in the push cycle into a two-entry queue.
// A pass-through frame moves from the queue into the result register once
// the back end is idle and the output is free. An upsampled frame starts
// from idle, gives one repeat per cycle while the receiver keeps up, takes
// in_rate off the phase a step at a time past the repeat cap, and retires.
// A downsampled frame that leaves its span open goes through the accumulate
// state back to idle; a span close runs a one-bit-a-cycle divider over every
// channel and then emits the averages.
// Reset clears phase, sums, queue and result register; registers return
// to their defaults. When the receiver stalls the result register holds
// and the back end waits; the queue absorbs two frames before full rises.
module ulaw_decode_rate_converter #(
   parameter int unsigned MAX_CHANNELS = ulrc_pkg::MAX_CHANNELS_DEF,
   parameter int unsigned MAX_RATIO    = ulrc_pkg::MAX_RATIO_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [15:0] req_sample_0, req_sample_1, req_sample_2, req_sample_3,
   input  logic [15:0] req_sample_4, req_sample_5, req_sample_6, req_sample_7,
   input  logic req_restart,
   output logic empty,
   input  logic pop,
   output logic signed [15:0] rsp_out_0, rsp_out_1, rsp_out_2, rsp_out_3,
   output logic signed [15:0] rsp_out_4, rsp_out_5, rsp_out_6, rsp_out_7,
   output logic rsp_last,
   input  logic csr_we,
   input  logic [ulrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ulrc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ulrc_pkg::*;

   logic              ulaw_ff;
   logic [RATE_W-1:0] in_rate_ff, out_rate_ff;
   logic [CHAN_W-1:0] chan_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ulaw_ff     <= 1'b0;
         in_rate_ff  <= RATE_RESET;
         out_rate_ff <= RATE_RESET;
         chan_ff     <= CHAN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ULAW:     ulaw_ff     <= csr_wdata[0];
            CSR_IN_RATE:  in_rate_ff  <= csr_wdata;
            CSR_OUT_RATE: out_rate_ff <= csr_wdata;
            CSR_CHANNELS: chan_ff     <= csr_wdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   logic [7:0][15:0] raw8;
   assign raw8 = {req_sample_7, req_sample_6, req_sample_5, req_sample_4,
                  req_sample_3, req_sample_2, req_sample_1, req_sample_0};

   logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] raw, f_frame, b_frame, rdata;
   always_comb for (int c = 0; c < int'(MAX_CHANNELS); c++) raw[c] = raw8[c];

   logic q_full, q_push, f_restart, b_restart, in_ready;
   mode_type f_mode, b_mode;
   logic [RATE_W-1:0] f_ir, f_or, b_ir, b_or;
   logic [CHAN_W-1:0] f_nch, b_nch;

   ulrc_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
      .in_valid(push), .in_raw(raw),
      .in_restart(req_restart), .ulaw_enable(ulaw_ff), .in_rate(in_rate_ff),
      .out_rate(out_rate_ff), .channel_count(chan_ff), .q_full(q_full),
      .in_ready(in_ready), .q_push(q_push), .q_frame(f_frame),
      .q_restart(f_restart), .q_mode(f_mode), .q_ir(f_ir), .q_or(f_or),
      .q_nch(f_nch));

   assign full = !in_ready;

   localparam int unsigned QW = MAX_CHANNELS*SAMPLE_W + 1 + 2 + 2*RATE_W + CHAN_W;
   logic [QW-1:0] q_in, q_out;
   logic q_empty, q_pop;
   logic [1:0] b_mode_bits;
   assign q_in = {f_frame, f_restart, 2'(f_mode), f_ir, f_or, f_nch};
   assign {b_frame, b_restart, b_mode_bits, b_ir, b_or, b_nch} = q_out;
   assign b_mode = mode_type'(b_mode_bits);

   ulrc_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in),
      .full(q_full), .pop(q_pop), .pop_data(q_out), .empty(q_empty));

   logic rvalid;
   ulrc_back #(.MAX_CHANNELS(MAX_CHANNELS), .MAX_RATIO(MAX_RATIO)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(!q_empty), .cmd_pop(q_pop),
      .cmd_frame(b_frame), .cmd_restart(b_restart), .cmd_mode(b_mode),
      .cmd_ir(b_ir), .cmd_or(b_or), .cmd_nch(b_nch), .rsp_valid(rvalid),
      .rsp_take(pop && rvalid), .rsp_data(rdata), .rsp_last(rsp_last));

   assign empty = !rvalid;
   logic [7:0][15:0] out8;
   always_comb begin
      out8 = '0;
      for (int c = 0; c < int'(MAX_CHANNELS); c++) out8[c] = rdata[c];
   end
   assign {rsp_out_7, rsp_out_6, rsp_out_5, rsp_out_4,
           rsp_out_3, rsp_out_2, rsp_out_1, rsp_out_0} = out8;

   // result register keeps its beat while the receiver stalls
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_0) && $stable(rsp_last)))
      else $error("result changed under stall");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (full |-> q_full)) else $error("full without queue full");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (q_pop |-> !q_empty)) else $error("pop from empty command queue");
endmodule

// ===== tb/ulaw_decode_rate_converter_chk.sv =====
// Checker for the rate converter: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module ulaw_decode_rate_converter_chk
   import ulrc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic full,
   input  logic [15:0] req_sample [8],
   input  logic req_restart,
   input  logic empty,
   input  logic pop,
   input  logic signed [15:0] rsp_out [8],
   input  logic rsp_last,
   input  logic csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int   fail_count,
   output int   frames_pending
);

   typedef struct packed {
      logic [7:0][15:0] pcm;
      logic             last;
   } out_frame_type;

   // register copies and converter state
   logic              ulaw_on;
   logic [RATE_W-1:0] rate_in, rate_out;
   logic [CHAN_W-1:0] chans;
   int unsigned       phase;
   int                sums [8];
   int unsigned       frames_in_span;
   out_frame_type     expected_frames [$];

   assign frames_pending = expected_frames.size();

   function automatic int mulaw_linear(logic [7:0] code);
      logic [7:0] u;
      int         t;
      u = ~code;
      t = ((u[3:0] << 3) + 'h84) << u[6:4];
      return u[7] ? ('h84 - t) : (t - 'h84);
   endfunction

   function automatic int unsigned sat_rate(logic [RATE_W-1:0] r);
      if (r < 8000) return 8000;
      if (r > 192000) return 192000;
      return r;
   endfunction

   function automatic out_frame_type make_frame(int vals [8], int unsigned nch, logic lst);
      out_frame_type f;
      for (int j = 0; j < 8; j++) f.pcm[j] = (j < nch) ? 16'(vals[j]) : 16'd0;
      f.last = lst;
      return f;
   endfunction

   // predict the output frames for one accepted input frame
   task automatic convert_frame(logic [15:0] raw [8], logic rst);
      int          frame [8];
      int          avg [8];
      int unsigned nch, ir, orr, n;
      nch = chans;
      if (nch < 1) nch = 1;
      if (nch > 8) nch = 8;
      ir  = sat_rate(rate_in);
      orr = sat_rate(rate_out);
      n   = 0;
      for (int c = 0; c < 8; c++) begin
         if (c >= nch) frame[c] = 0;
         else if (ulaw_on) frame[c] = mulaw_linear(raw[c][7:0]);
         else frame[c] = $signed(raw[c]);
      end
      if (rst) begin
         phase = 0;
         frames_in_span = 0;
         for (int c = 0; c < 8; c++) sums[c] = 0;
      end
      if (ir == orr) begin
         expected_frames.push_back(make_frame(frame, nch, 1'b1));
      end else if (orr > ir) begin
         phase += orr;
         while (phase >= ir && n < MAX_RATIO_DEF) begin
            phase -= ir;
            n++;
         end
         phase %= ir;
         for (int k = 0; k < n; k++)
            expected_frames.push_back(make_frame(frame, nch, k + 1 == n));
      end else begin
         for (int c = 0; c < nch; c++) sums[c] += frame[c];
         frames_in_span++;
         phase += orr;
         if (phase >= ir || frames_in_span >= MAX_RATIO_DEF) begin
            if (phase >= ir) phase -= ir;
            for (int c = 0; c < 8; c++)
               avg[c] = (c < nch) ? sums[c] / int'(frames_in_span) : 0;
            for (int c = 0; c < 8; c++) sums[c] = 0;
            frames_in_span = 0;
            expected_frames.push_back(make_frame(avg, nch, 1'b1));
         end
      end
   endtask

   // sample at the rising edge: register writes, input beats, output beats
   always @(posedge clock) begin
      out_frame_type want, got;
      if (reset) begin
         ulaw_on = 1'b0;
         rate_in = RATE_RESET;
         rate_out = RATE_RESET;
         chans = CHAN_RESET;
         phase = 0;
         frames_in_span = 0;
         for (int c = 0; c < 8; c++) sums[c] = 0;
         expected_frames.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ULAW:     ulaw_on = csr_wdata[0];
               CSR_IN_RATE:  rate_in = csr_wdata[RATE_W-1:0];
               CSR_OUT_RATE: rate_out = csr_wdata[RATE_W-1:0];
               CSR_CHANNELS: chans = csr_wdata[CHAN_W-1:0];
               default: ;
            endcase
         end
         if (pop && !empty) begin
            for (int j = 0; j < 8; j++) got.pcm[j] = rsp_out[j];
            got.last = rsp_last;
            if (expected_frames.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected output beat %h", got);
            end else begin
               want = expected_frames.pop_front();
               for (int j = 0; j < 8; j++)
                  if (got.pcm[j] !== want.pcm[j]) begin
                     fail_count++;
                     if (fail_count <= 10)
                        $display("out_%0d: expected %0d, got %0d", j,
                                 $signed(want.pcm[j]), $signed(got.pcm[j]));
                  end
               if (got.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("last: expected %b, got %b", want.last, got.last);
               end
            end
         end
         if (push && !full) convert_frame(req_sample, req_restart);
      end
   end

endmodule

// ===== tb/ulaw_decode_rate_converter_tb.sv =====
// Testbench top: clock, reset, register settings, frame stimulus and verdict.
`timescale 1ns / 100ps
module ulaw_decode_rate_converter_tb;
   import ulrc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full, empty;
   logic pop = 1'b0;
   logic [15:0] req_sample [8];
   logic req_restart = 1'b0;
   logic signed [15:0] rsp_out [8];
   logic rsp_last;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ULAW;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int   fail_count, frames_pending;
   int   cycle_count = 0;
   bit   hold_pop = 1'b0;
   bit   burst_on = 1'b0;

   initial for (int i = 0; i < 8; i++) req_sample[i] = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   ulaw_decode_rate_converter dut (
      .clock, .reset, .push, .full,
      .req_sample_0(req_sample[0]), .req_sample_1(req_sample[1]),
      .req_sample_2(req_sample[2]), .req_sample_3(req_sample[3]),
      .req_sample_4(req_sample[4]), .req_sample_5(req_sample[5]),
      .req_sample_6(req_sample[6]), .req_sample_7(req_sample[7]),
      .req_restart, .empty, .pop,
      .rsp_out_0(rsp_out[0]), .rsp_out_1(rsp_out[1]), .rsp_out_2(rsp_out[2]),
      .rsp_out_3(rsp_out[3]), .rsp_out_4(rsp_out[4]), .rsp_out_5(rsp_out[5]),
      .rsp_out_6(rsp_out[6]), .rsp_out_7(rsp_out[7]),
      .rsp_last, .csr_we, .csr_index, .csr_wdata
   );

   ulaw_decode_rate_converter_chk checker_i (
      .clock, .reset, .push, .full, .req_sample, .req_restart, .empty, .pop,
      .rsp_out, .rsp_last, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .frames_pending
   );

   // timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 1500000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver stall pattern, overridden by the long hold-off
   always @(negedge clock) begin
      if (hold_pop) pop <= 1'b0;
      else if (cycle_count % 1024 < 300) pop <= 1'b1;
      else pop <= ($urandom_range(0, 3) != 0);
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_mode(bit ulaw, int unsigned ir, int unsigned orr, int unsigned nch);
      write_reg(CSR_ULAW, CSR_DATA_W'(ulaw));
      write_reg(CSR_IN_RATE, CSR_DATA_W'(ir));
      write_reg(CSR_OUT_RATE, CSR_DATA_W'(orr));
      write_reg(CSR_CHANNELS, CSR_DATA_W'(nch));
   endtask

   // drain outstanding frames, then let a span close settle
   task automatic drain();
      while (frames_pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   // one input beat; gaps between bursts; called at a falling edge
   task automatic send_frame(logic [15:0] s [8], logic rst);
      if (!burst_on) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_on = 1'b1;
      end
      for (int i = 0; i < 8; i++) req_sample[i] <= s[i];
      req_restart <= rst;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      if ($urandom_range(0, 5) == 0) burst_on = 1'b0;
      if (!burst_on) push <= 1'b0;
   endtask

   task automatic send_random(int count, int restart_pct);
      logic [15:0] s [8];
      for (int k = 0; k < count; k++) begin
         for (int i = 0; i < 8; i++) s[i] = 16'($urandom);
         send_frame(s, $urandom_range(0, 99) < restart_pct);
      end
      push <= 1'b0;
      burst_on = 1'b0;
   endtask

   initial begin
      logic [15:0] s [8];
      int          rates [6] = '{8000, 11025, 44100, 48000, 96000, 192000};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes at reset settings (pass-through, 2 channels)
      for (int i = 0; i < 8; i++) s[i] = 16'h8000;
      send_frame(s, 1'b1);
      for (int i = 0; i < 8; i++) s[i] = 16'h7FFF;
      send_frame(s, 1'b0);
      for (int i = 0; i < 8; i++) s[i] = 16'hFFFF;
      send_frame(s, 1'b0);
      for (int i = 0; i < 8; i++) s[i] = 16'h0000;
      send_frame(s, 1'b0);
      push <= 1'b0;
      burst_on = 1'b0;
      drain();
      // mu-law codes at the ends with the high byte set or clear, 8 channels
      set_mode(1'b1, 48000, 48000, 8);
      for (int i = 0; i < 8; i++) s[i] = {8'hA5, 8'(i * 32 + (i & 1) * 127)};
      send_frame(s, 1'b0);
      for (int i = 0; i < 8; i++) s[i] = {8'hFF, (i < 4) ? 8'h00 : 8'hFF};
      send_frame(s, 1'b0);
      for (int i = 0; i < 8; i++) s[i] = {8'h00, (i < 4) ? 8'h7F : 8'h80};
      send_frame(s, 1'b0);
      push <= 1'b0;
      burst_on = 1'b0;
      drain();
      // upsampling cap: out rate above range, in rate below range, channels 0
      set_mode(1'b0, 100, 250000, 0);
      send_random(3, 0);
      drain();
      // downsampling cap: span closes on frame count, channels above range
      set_mode(1'b1, 192000, 8000, 15);
      send_random(26, 0);
      drain();
      // downsample with restart mid-span
      set_mode(1'b0, 44100, 8000, 8);
      send_random(4, 0);
      for (int i = 0; i < 8; i++) s[i] = 16'h8000;
      send_frame(s, 1'b1);
      push <= 1'b0;
      burst_on = 1'b0;
      drain();

      // random phases through several settings
      for (int ph = 0; ph < 8; ph++) begin
         set_mode($urandom_range(0, 1), rates[$urandom_range(0, 5)],
                  rates[$urandom_range(0, 5)], $urandom_range(0, 15));
         if (ph == 3) begin
            // long hold-off while frames keep coming
            fork
               begin
                  hold_pop = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_pop = 1'b0;
               end
               send_random(40, 3);
            join
         end else begin
            send_random(40, 3);
         end
         drain();
      end

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ulrc_pkg.sv
rtl/ulrc_front.sv
rtl/ulrc_fifo.sv
rtl/ulrc_back.sv
rtl/ulaw_decode_rate_converter.sv
tb/ulaw_decode_rate_converter_chk.sv
tb/ulaw_decode_rate_converter_tb.sv
